// ===== src/alist_pkg.sv =====
// Shared types and constants for the array list block.
// Used by alist_mem and array_list_insert_remove; no dependencies.
`timescale 1ns / 1ps

package alist_pkg;

  // Storage size and derived widths
  localparam int CAPACITY = 8;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = ((LEN_W > 4) ? LEN_W : 4) + 1;

  // Item field widths
  localparam int OP_W     = 3;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 4;
  localparam int STAT_W   = 2;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 48;

  // Opcodes
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_FR = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AT = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_BK = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
  localparam logic [OP_W-1:0] OP_LIST   = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK,
    ST_FINISH,
    ST_RESP
  } state_e;

  // What the walk does with each slot it reads
  typedef enum logic [1:0] {
    WM_SHIFT_UP,
    WM_SHIFT_DN,
    WM_COMPACT,
    WM_LIST
  } walk_mode_e;

  // Key store access for one cycle
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== src/array_list_insert_remove.sv =====
// Top level of the array list: sequencer, window registers and output item register.
// Depends on alist_pkg and alist_mem.
//
//   channel  | dir | tdata (low bit first)                          | tlast
//   s_axis   | in  | opcode[2:0] key_value[34:3] position[38:35]    | -
//   m_axis   | out | status[1:0] item_value[33:2] item_position     | last
//            |     | [37:34] list_length[41:38]                     |
//
// An item passes through decode, a walk over up to CAPACITY slots through the single
// read port of the key store (one read per cycle unless a stalled output holds it,
// with registered read data), then finish and respond; the idle state then takes the
// next item. Clear, a rejected insert and a list or remove on an empty list go from
// decode straight to respond. A list item gives one result per held key at one per cycle
// while m_axis takes them and goes back to idle after its last result, skipping finish and respond.
// Reset empties the window; key slots are not cleared. A new item is taken while
// the previous result still waits in the output register; a stalled output holds
// a list walk.
`timescale 1ns / 1ps

module array_list_insert_remove (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // opcode[2:0], key_value[34:3], position[38:35], zero[39]
  input  logic [alist_pkg::IN_W-1:0]   s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // status[1:0], item_value[33:2], item_position[37:34], list_length[41:38], zero[47:42]
  output logic [alist_pkg::OUT_W-1:0]  m_axis_tdata_o,
  output logic                         m_axis_tlast_o
);
  import alist_pkg::*;

  // Architectural window
  logic [IDX_W-1:0]  first_q, first_d;
  logic [IDX_W-1:0]  last_q, last_d;
  logic              empty_q, empty_d;

  // Sequencer
  state_e            state_q, state_d;
  walk_mode_e        mode_q, mode_d;
  logic [OP_W-1:0]   op_q;
  logic [KEY_W-1:0]  key_q;
  logic [POS_W-1:0]  pos_q;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic [IDX_W-1:0]  key_addr_q, key_addr_d;
  logic [IDX_W-1:0]  src_q, src_d;
  logic [IDX_W-1:0]  tag_q, tag_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  n_q, n_d;
  logic [LEN_W-1:0]  lpos_q, lpos_d;
  logic              rdv_q, rdv_d;

  // Output item register
  logic              out_valid_q, out_valid_d;
  logic [OUT_W-1:0]  out_data_q, out_data_d;
  logic              out_last_q, out_last_d;

  logic              in_acc;
  logic              out_free;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  p;
  logic              pos_bad;
  logic              issue;
  logic              consume;
  logic              walk_done;
  logic              is_insert;
  logic [KEY_W-1:0]  rdata;
  mem_req_t          mreq;

  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign is_insert       = (op_q == OP_INS_FR) || (op_q == OP_INS_AT) || (op_q == OP_INS_BK);

  // Held count
  assign len = empty_q ? '0 : LEN_W'(LEN_W'(last_q) - LEN_W'(first_q) + LEN_W'(1));

  // Insert position and its check
  assign pos_bad = (pos_q == '0) ||
                   (CMP_W'(pos_q) > (CMP_W'(len) + CMP_W'(1)));
  always_comb begin
    case (op_q)
      OP_INS_FR: p = LEN_W'(1);
      OP_INS_BK: p = len + LEN_W'(1);
      default:   p = LEN_W'(pos_q);
    endcase
  end

  // Walk handshake with the read port
  assign consume   = rdv_q && ((mode_q != WM_LIST) || out_free);
  assign issue     = (state_q == ST_WALK) && (cnt_q != '0) &&
                     (!rdv_q || consume);
  assign walk_done = (cnt_q == '0) && (!rdv_q || consume);

  alist_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mreq),
    .rdata_o (rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (op_q == OP_LIST) begin
          state_d = empty_q ? ST_RESP : ST_WALK;
        end else if (op_q == OP_REMOVE) begin
          state_d = empty_q ? ST_RESP : ST_WALK;
        end else if (is_insert) begin
          if (len == LEN_W'(CAPACITY) || (op_q == OP_INS_AT && pos_bad)) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_WALK;
          end
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_WALK: begin
        if (walk_done) state_d = (mode_q == WM_LIST) ? ST_IDLE : ST_FINISH;
      end
      ST_FINISH: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    first_d     = first_q;
    last_d      = last_q;
    empty_d     = empty_q;
    mode_d      = mode_q;
    stat_d      = stat_q;
    key_addr_d  = key_addr_q;
    src_d       = src_q;
    tag_d       = tag_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    lpos_d      = lpos_q;
    rdv_d       = rdv_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    mreq        = '0;
    mreq.raddr  = src_q;
    mreq.waddr  = tag_q;
    mreq.wdata  = rdata;

    unique case (state_q)
      ST_IDLE: ;
      ST_DECODE: begin
        stat_d = STAT_OK;
        cnt_d  = '0;
        n_d    = '0;
        lpos_d = LEN_W'(1);
        rdv_d  = 1'b0;
        src_d  = first_q;
        if (op_q == OP_CLEAR) begin
          first_d = '0;
          last_d  = '0;
          empty_d = 1'b1;
        end else if (op_q == OP_LIST) begin
          mode_d = WM_LIST;
          cnt_d  = len;
          if (empty_q) stat_d = STAT_EMPTY;
        end else if (op_q == OP_REMOVE) begin
          mode_d = WM_COMPACT;
          cnt_d  = len;
        end else if (is_insert) begin
          mode_d = WM_SHIFT_UP;
          if (len == LEN_W'(CAPACITY)) begin
            stat_d = STAT_FULL;
          end else if (op_q == OP_INS_AT && pos_bad) begin
            stat_d = STAT_BADPOS;
          end else if (empty_q) begin
            key_addr_d = '0;
            first_d    = '0;
            last_d     = '0;
            empty_d    = 1'b0;
          end else if (last_q != IDX_W'(CAPACITY - 1)) begin
            if (op_q == OP_INS_BK) begin
              key_addr_d = last_q + IDX_W'(1);
              last_d     = last_q + IDX_W'(1);
            end else if (op_q == OP_INS_FR && first_q != '0) begin
              key_addr_d = first_q - IDX_W'(1);
              first_d    = first_q - IDX_W'(1);
            end else begin
              // open a slot by moving positions p..len one slot up
              key_addr_d = IDX_W'(LEN_W'(first_q) + p - LEN_W'(1));
              src_d      = last_q;
              cnt_d      = len - p + LEN_W'(1);
              last_d     = last_q + IDX_W'(1);
            end
          end else begin
            // back is full: move positions 1..p-1 one slot down
            mode_d     = WM_SHIFT_DN;
            key_addr_d = IDX_W'(LEN_W'(first_q) + p - LEN_W'(2));
            cnt_d      = p - LEN_W'(1);
            first_d    = first_q - IDX_W'(1);
          end
        end
      end
      ST_WALK: begin
        // read side
        if (issue) begin
          mreq.re = 1'b1;
          cnt_d   = cnt_q - LEN_W'(1);
          if (mode_q == WM_SHIFT_DN) begin
            src_d = src_q + IDX_W'(1);
            tag_d = src_q - IDX_W'(1);
          end else if (mode_q == WM_SHIFT_UP) begin
            src_d = src_q - IDX_W'(1);
            tag_d = src_q + IDX_W'(1);
          end else begin
            src_d = src_q + IDX_W'(1);
          end
        end
        if (issue) begin
          rdv_d = 1'b1;
        end else if (consume) begin
          rdv_d = 1'b0;
        end
        // returned slot
        if (consume) begin
          case (mode_q)
            WM_SHIFT_UP, WM_SHIFT_DN: mreq.we = 1'b1;
            WM_COMPACT: begin
              mreq.waddr = IDX_W'(n_q);
              if (rdata != key_q) begin
                mreq.we = 1'b1;
                n_d     = n_q + LEN_W'(1);
              end
            end
            default: begin
              out_valid_d = 1'b1;
              out_data_d  = {6'd0, 4'(len), 4'(lpos_q), rdata, STAT_OK};
              out_last_d  = (cnt_q == '0);
              lpos_d      = lpos_q + LEN_W'(1);
            end
          endcase
        end
      end
      ST_FINISH: begin
        if (is_insert) begin
          mreq.we    = 1'b1;
          mreq.waddr = key_addr_q;
          mreq.wdata = key_q;
        end else begin
          first_d = '0;
          if (n_q == '0) begin
            last_d  = '0;
            empty_d = 1'b1;
          end else begin
            last_d  = IDX_W'(n_q - LEN_W'(1));
            empty_d = 1'b0;
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {6'd0, 4'(len), 4'd0, {KEY_W{1'b0}}, stat_q};
          out_last_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= '0;
      last_q      <= '0;
      empty_q     <= 1'b1;
      rdv_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      last_q      <= last_d;
      empty_q     <= empty_d;
      rdv_q       <= rdv_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= s_axis_tdata_i[OP_W-1:0];
      key_q <= s_axis_tdata_i[OP_W+KEY_W-1:OP_W];
      pos_q <= s_axis_tdata_i[OP_W+KEY_W+POS_W-1:OP_W+KEY_W];
    end
    mode_q     <= mode_d;
    stat_q     <= stat_d;
    key_addr_q <= key_addr_d;
    src_q      <= src_d;
    tag_q      <= tag_d;
    n_q        <= n_d;
    lpos_q     <= lpos_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== src/alist_mem.sv =====
// Key store: one write port, one read port with registered read data.
// Depends on alist_pkg for sizes and the request struct.
`timescale 1ns / 1ps

module alist_mem (
  input  logic                         clk_i,
  input  alist_pkg::mem_req_t          req_i,
  output logic [alist_pkg::KEY_W-1:0]  rdata_o
);
  import alist_pkg::*;

  logic [KEY_W-1:0] mem [CAPACITY];
  logic [KEY_W-1:0] rdata_q;

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
